>>> rtl/rrlg_pkg.sv
package rrlg_pkg;

    // LED string and hue scale
    localparam int LEDS         = 32;
    localparam int HUE_BASE     = 0;
    localparam int DEF_HUE_TURN = 5760;

    // field widths
    localparam int HUE_W      = 13;
    localparam int LED_W      = 6;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ROT_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT   = 2'd2;

    // reset values of the registers
    localparam logic signed [HUE_W-1:0] RST_ROT_STEP = 13'sd16;
    localparam logic [CHAN_W-1:0]       RST_SAT      = 8'd255;
    localparam logic [CHAN_W-1:0]       RST_BRIGHT   = 8'd255;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_WRAP
    } front_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bright;
    } color_cfg_t;

endpackage

>>> rtl/rrlg_in_if.sv
interface rrlg_in_if;
    logic valid;
    logic ready;
    logic frame_tick;

    modport source (output valid, output frame_tick, input ready);
    modport sink (input valid, input frame_tick, output ready);
endinterface

>>> rtl/rrlg_out_if.sv
interface rrlg_out_if;
    logic                        valid;
    logic                        ready;
    logic [rrlg_pkg::LED_W-1:0]  led_index;
    logic [rrlg_pkg::CHAN_W-1:0] red;
    logic [rrlg_pkg::CHAN_W-1:0] green;
    logic [rrlg_pkg::CHAN_W-1:0] blue;
    logic                        last_led;

    modport source (output valid, output led_index, output red, output green, output blue,
                    output last_led, input ready);
    modport sink (input valid, input led_index, input red, input green, input blue,
                  input last_led, output ready);
endinterface

>>> rtl/rrlg_front.sv
module rrlg_front #(
    parameter int HUE_TURN = rrlg_pkg::DEF_HUE_TURN
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rrlg_in_if.sink                           frame,
    input  logic signed [rrlg_pkg::HUE_W-1:0] rot_step,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [rrlg_pkg::HUE_W-1:0]        push_hue
);

    localparam int SumW = rrlg_pkg::HUE_W + 2;
    localparam logic signed [SumW-1:0] TurnS = SumW'(HUE_TURN);

    rrlg_pkg::front_state_t state_reg, state_next;
    logic signed [SumW-1:0] sum_reg, sum_next;
    logic [rrlg_pkg::HUE_W-1:0] base_reg, base_next;
    logic in_range;

    // one add or subtract of a turn per cycle until the hue is back in range
    assign in_range = !sum_reg[SumW-1] && (sum_reg < TurnS);

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        base_next  = base_reg;
        case (state_reg)
            rrlg_pkg::FRONT_IDLE:
            begin
                if (frame.valid && frame.frame_tick)
                begin
                    sum_next   = $signed({2'b00, base_reg}) + SumW'(rot_step);
                    state_next = rrlg_pkg::FRONT_WRAP;
                end
            end
            rrlg_pkg::FRONT_WRAP:
            begin
                if (sum_reg[SumW-1])
                begin
                    sum_next = sum_reg + TurnS;
                end
                else if (!in_range)
                begin
                    sum_next = sum_reg - TurnS;
                end
                else if (push_ready)
                begin
                    base_next  = sum_reg[rrlg_pkg::HUE_W-1:0];
                    state_next = rrlg_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = rrlg_pkg::FRONT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        frame.ready = 1'b0;
        push_valid  = 1'b0;
        push_hue    = sum_reg[rrlg_pkg::HUE_W-1:0];
        case (state_reg)
            rrlg_pkg::FRONT_IDLE: frame.ready = 1'b1;
            rrlg_pkg::FRONT_WRAP: push_valid  = in_range;
            default:              frame.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrlg_pkg::FRONT_IDLE;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

endmodule

>>> rtl/rrlg_queue.sv
module rrlg_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  logic [rrlg_pkg::HUE_W-1:0] push_data,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output logic [rrlg_pkg::HUE_W-1:0] pop_data
);

    // two-entry queue of frame base hues
    logic [rrlg_pkg::HUE_W-1:0] mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/rrlg_back.sv
module rrlg_back #(
    parameter int HUE_TURN = rrlg_pkg::DEF_HUE_TURN
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  logic [rrlg_pkg::HUE_W-1:0] pop_hue,
    input  rrlg_pkg::color_cfg_t       cfg,
    rrlg_out_if.source                 pixel
);

    localparam int HW    = rrlg_pkg::HUE_W;
    localparam int LW    = rrlg_pkg::LED_W;
    localparam int CW    = rrlg_pkg::CHAN_W;
    localparam int RemW  = LW + 1;
    localparam int H6W   = HW + 3;
    localparam int Span  = HUE_TURN - rrlg_pkg::HUE_BASE;
    localparam int StepQ = Span / rrlg_pkg::LEDS;
    localparam int StepR = Span % rrlg_pkg::LEDS;

    // all three channel levels are floor(v*(Den - s*y)/Den), y in {T, frac, T-frac}
    localparam int Den  = 255 * HUE_TURN;
    localparam int DenW = $clog2(Den + 1);
    localparam int NumW = CW + DenW;
    localparam int K    = NumW + $clog2(Den);
    localparam int MW   = NumW + 2;
    localparam int PW   = NumW + MW;
    localparam longint unsigned RecipL = ((64'd1 << K) + 64'(Den) - 64'd1) / 64'(Den);
    localparam logic [MW-1:0] Recip = MW'(RecipL);

    localparam logic [H6W-1:0] T1 = H6W'(HUE_TURN);
    localparam logic [H6W-1:0] T2 = H6W'(2 * HUE_TURN);
    localparam logic [H6W-1:0] T3 = H6W'(3 * HUE_TURN);
    localparam logic [H6W-1:0] T4 = H6W'(4 * HUE_TURN);
    localparam logic [H6W-1:0] T5 = H6W'(5 * HUE_TURN);

    typedef enum logic [2:0] {
        SEC_RY,
        SEC_YG,
        SEC_GC,
        SEC_CB,
        SEC_BM,
        SEC_MR
    } sector_t;

    typedef struct packed {
        logic [LW-1:0] idx;
        logic          last;
        sector_t       sec;
    } meta_t;

    // LED sequencer
    logic            busy_reg, busy_next;
    logic [LW-1:0]   led_reg, led_next;
    logic [HW-1:0]   offq_reg, offq_next;
    logic [RemW-1:0] offr_reg, offr_next;
    logic [HW-1:0]   base_reg;
    logic [RemW-1:0] rem_sum;
    logic [HW:0]     hue_sum;
    logic [HW-1:0]   hue_wrap;
    logic            led_last;
    logic            adv;
    logic            load;

    // pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    meta_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, mo_reg;
    meta_t m1_next;
    logic [HW-1:0]   hue1_reg;
    logic [H6W-1:0]  h6;
    sector_t         sec_c;
    logic [HW-1:0]   frac_c;
    logic [HW-1:0]   frac2_reg;
    logic [DenW-1:0] xq3_reg, xt3_reg, xp3_reg;
    logic [NumW-1:0] nq4_reg, nt4_reg, np4_reg;
    logic [PW-1:0]   pq5_reg, pt5_reg, pp5_reg;
    logic [CW-1:0]   q_c, t_c, p_c, v_c;
    logic [CW-1:0]   red_c, green_c, blue_c;
    logic [CW-1:0]   red_reg, green_reg, blue_reg;

    // whole pipeline moves when the output stage is empty or being taken
    assign adv       = !vo_reg || pixel.ready;
    assign pop_ready = !busy_reg;
    assign load      = pop_valid && !busy_reg;
    assign led_last  = (led_reg == LW'(rrlg_pkg::LEDS - 1));
    assign rem_sum   = offr_reg + RemW'(StepR);
    assign hue_sum   = {1'b0, base_reg} + {1'b0, offq_reg};
    assign hue_wrap  = (hue_sum >= (HW + 1)'(HUE_TURN)) ?
                       HW'(hue_sum - (HW + 1)'(HUE_TURN)) : HW'(hue_sum);

    always_comb
    begin
        busy_next = busy_reg;
        led_next  = led_reg;
        offq_next = offq_reg;
        offr_next = offr_reg;
        if (!busy_reg)
        begin
            if (pop_valid)
            begin
                busy_next = 1'b1;
                led_next  = '0;
                offq_next = '0;
                offr_next = '0;
            end
        end
        else if (adv)
        begin
            busy_next = !led_last;
            led_next  = led_reg + LW'(1);
            if (rem_sum >= RemW'(rrlg_pkg::LEDS))
            begin
                offr_next = rem_sum - RemW'(rrlg_pkg::LEDS);
                offq_next = offq_reg + HW'(StepQ + 1);
            end
            else
            begin
                offr_next = rem_sum;
                offq_next = offq_reg + HW'(StepQ);
            end
        end
    end

    always_comb
    begin
        m1_next.idx  = led_reg;
        m1_next.last = led_last;
        m1_next.sec  = SEC_RY;
    end

    // sector and fraction of 6*hue against multiples of a turn
    always_comb
    begin
        h6 = (H6W'(hue1_reg) << 2) + (H6W'(hue1_reg) << 1);
        if (h6 >= T5)
        begin
            sec_c  = SEC_MR;
            frac_c = HW'(h6 - T5);
        end
        else if (h6 >= T4)
        begin
            sec_c  = SEC_BM;
            frac_c = HW'(h6 - T4);
        end
        else if (h6 >= T3)
        begin
            sec_c  = SEC_CB;
            frac_c = HW'(h6 - T3);
        end
        else if (h6 >= T2)
        begin
            sec_c  = SEC_GC;
            frac_c = HW'(h6 - T2);
        end
        else if (h6 >= T1)
        begin
            sec_c  = SEC_YG;
            frac_c = HW'(h6 - T1);
        end
        else
        begin
            sec_c  = SEC_RY;
            frac_c = HW'(h6);
        end
    end

    assign q_c = pq5_reg[K +: CW];
    assign t_c = pt5_reg[K +: CW];
    assign p_c = pp5_reg[K +: CW];
    assign v_c = cfg.bright;

    always_comb
    begin
        case (m5_reg.sec)
            SEC_RY:
            begin
                red_c = v_c; green_c = t_c; blue_c = p_c;
            end
            SEC_YG:
            begin
                red_c = q_c; green_c = v_c; blue_c = p_c;
            end
            SEC_GC:
            begin
                red_c = p_c; green_c = v_c; blue_c = t_c;
            end
            SEC_CB:
            begin
                red_c = p_c; green_c = q_c; blue_c = v_c;
            end
            SEC_BM:
            begin
                red_c = t_c; green_c = p_c; blue_c = v_c;
            end
            default:
            begin
                red_c = v_c; green_c = p_c; blue_c = q_c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            led_reg  <= '0;
            offq_reg <= '0;
            offr_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vo_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            led_reg  <= led_next;
            offq_reg <= offq_next;
            offr_reg <= offr_next;
            if (adv)
            begin
                v1_reg <= busy_reg;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                vo_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            base_reg <= pop_hue;
        end
        if (adv)
        begin
            m1_reg    <= m1_next;
            hue1_reg  <= hue_wrap;

            m2_reg    <= '{idx: m1_reg.idx, last: m1_reg.last, sec: sec_c};
            frac2_reg <= frac_c;

            m3_reg  <= m2_reg;
            xq3_reg <= DenW'(cfg.sat) * DenW'(frac2_reg);
            xt3_reg <= DenW'(cfg.sat) * DenW'(HW'(HUE_TURN) - frac2_reg);
            xp3_reg <= DenW'(cfg.sat) * DenW'(HUE_TURN);

            m4_reg  <= m3_reg;
            nq4_reg <= NumW'(cfg.bright) * NumW'(DenW'(Den) - xq3_reg);
            nt4_reg <= NumW'(cfg.bright) * NumW'(DenW'(Den) - xt3_reg);
            np4_reg <= NumW'(cfg.bright) * NumW'(DenW'(Den) - xp3_reg);

            m5_reg  <= m4_reg;
            pq5_reg <= PW'(nq4_reg) * PW'(Recip);
            pt5_reg <= PW'(nt4_reg) * PW'(Recip);
            pp5_reg <= PW'(np4_reg) * PW'(Recip);

            mo_reg    <= m5_reg;
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
        end
    end

    assign pixel.valid     = vo_reg;
    assign pixel.led_index = mo_reg.idx;
    assign pixel.last_led  = mo_reg.last;
    assign pixel.red       = red_reg;
    assign pixel.green     = green_reg;
    assign pixel.blue      = blue_reg;

endmodule

>>> rtl/rotating_rainbow_led_generator.sv
// Channel   Dir  Word                                   Handshake
// frame     in   frame_tick                             valid/ready
// pixel     out  led_index, red, green, blue, last_led  valid/ready
// wr_*      in   wr_index, wr_data                      wr_en, no stall
//
// A tick of 1 holds the front while it adds the step, wraps the sum by whole
// turns and waits for the queue to take it; a tick of 0 is taken and dropped.
// The back sends LEDS pixel words per frame, one per cycle within a frame
// while pixel.ready stays high. Up to two wrapped base hues wait in the
// queue, so ticks keep coming in while the back is busy. Low pixel.ready
// freezes the whole back pipeline when a word waits at the output.
// Reset is async: base hue 0, step 16, saturation and brightness 255.
module rotating_rainbow_led_generator #(
    parameter int HUE_TURN = rrlg_pkg::DEF_HUE_TURN
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rrlg_in_if.sink                             frame,
    rrlg_out_if.source                          pixel,
    input  logic                                wr_en,
    input  logic [rrlg_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [rrlg_pkg::CFG_DATA_W-1:0]     wr_data
);

    // config registers
    logic signed [rrlg_pkg::HUE_W-1:0] step_reg, step_next;
    logic [rrlg_pkg::CHAN_W-1:0]       sat_reg, sat_next;
    logic [rrlg_pkg::CHAN_W-1:0]       bright_reg, bright_next;
    rrlg_pkg::color_cfg_t              color_cfg;

    // front to queue to back
    logic                       push_valid, push_ready;
    logic [rrlg_pkg::HUE_W-1:0] push_hue;
    logic                       pop_valid, pop_ready;
    logic [rrlg_pkg::HUE_W-1:0] pop_hue;

    // register writes; unknown indexes fall through
    always_comb
    begin
        step_next   = step_reg;
        sat_next    = sat_reg;
        bright_next = bright_reg;
        if (wr_en)
        begin
            case (wr_index)
                rrlg_pkg::REG_ROT_STEP: step_next   = $signed(wr_data[rrlg_pkg::HUE_W-1:0]);
                rrlg_pkg::REG_SAT:      sat_next    = wr_data[rrlg_pkg::CHAN_W-1:0];
                rrlg_pkg::REG_BRIGHT:   bright_next = wr_data[rrlg_pkg::CHAN_W-1:0];
                default:                step_next   = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= rrlg_pkg::RST_ROT_STEP;
            sat_reg    <= rrlg_pkg::RST_SAT;
            bright_reg <= rrlg_pkg::RST_BRIGHT;
        end
        else
        begin
            step_reg   <= step_next;
            sat_reg    <= sat_next;
            bright_reg <= bright_next;
        end
    end

    assign color_cfg.sat    = sat_reg;
    assign color_cfg.bright = bright_reg;

    // front: takes ticks, advances and wraps the base hue
    rrlg_front #(
        .HUE_TURN (HUE_TURN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .rot_step   (step_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_hue   (push_hue)
    );

    // queue of pending frame base hues
    rrlg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_hue),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_hue)
    );

    // back: walks the LEDs and converts each hue to RGB
    rrlg_back #(
        .HUE_TURN (HUE_TURN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_hue   (pop_hue),
        .cfg       (color_cfg),
        .pixel     (pixel)
    );

endmodule

>>> rtl/rrlg_checker.sv
module rrlg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_tick,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rrlg_pkg::LED_W-1:0]  out_index,
    input logic [rrlg_pkg::CHAN_W-1:0] out_red,
    input logic [rrlg_pkg::CHAN_W-1:0] out_green,
    input logic [rrlg_pkg::CHAN_W-1:0] out_blue,
    input logic                        out_last
);

    logic [rrlg_pkg::LED_W-1:0] expect_reg, expect_next;

    always_comb
    begin
        expect_next = expect_reg;
        if (out_valid && out_ready)
        begin
            expect_next = out_last ? '0 : out_index + rrlg_pkg::LED_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg <= '0;
        end
        else
        begin
            expect_reg <= expect_next;
        end
    end

    // LEDs come out in order, every frame from LED 0
    a_led_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_index == expect_reg)
        else $error("pixel word out of LED order");

    // last flag marks exactly the final LED
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == rrlg_pkg::LED_W'(rrlg_pkg::LEDS - 1))))
        else $error("last_led does not match final LED");

    // front is busy wrapping after a real tick
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_tick |=> !in_ready)
        else $error("front took a word while wrapping hue");

    // stalled pixel word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(out_last))
        else $error("stalled pixel word changed");

endmodule

bind rotating_rainbow_led_generator rrlg_checker u_rrlg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .in_tick   (frame.frame_tick),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .out_index (pixel.led_index),
    .out_red   (pixel.red),
    .out_green (pixel.green),
    .out_blue  (pixel.blue),
    .out_last  (pixel.last_led)
);

>>> sim/tb_rotating_rainbow_led_generator.sv
`timescale 1ns / 1ps

module tb_rotating_rainbow_led_generator;

    // DUT runs with its default hue scale: 1/16 degree, 5760 per turn
    localparam int HUE_TURN      = rrlg_pkg::DEF_HUE_TURN;
    localparam int HUE_SPAN      = HUE_TURN - rrlg_pkg::HUE_BASE;
    localparam int RANDOM_FRAMES = 360;
    // tick 0 is dropped by the DUT; a few spare cycles before a register write
    localparam int SETTLE_CYCLES = 8;
    // pipeline fill plus one whole frame, to catch stray words at the end
    localparam int TAIL_CYCLES   = 48;
    // cycles in a row with no word moving on either channel
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;

    // index 3 is not mapped; writes to it must be ignored
    localparam logic [rrlg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic [rrlg_pkg::LED_W-1:0]  led_index;
        logic [rrlg_pkg::CHAN_W-1:0] red;
        logic [rrlg_pkg::CHAN_W-1:0] green;
        logic [rrlg_pkg::CHAN_W-1:0] blue;
        logic                        last_led;
    } pixel_word_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [rrlg_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [rrlg_pkg::CFG_DATA_W-1:0] wr_data;

    rrlg_in_if  frame_if ();
    rrlg_out_if pixel_if ();

    rotating_rainbow_led_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame_if),
        .pixel    (pixel_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // predictor state: own copy of the ring hue and the color registers
    int unsigned                       ring_hue;
    logic signed [rrlg_pkg::HUE_W-1:0] hue_step;
    logic [rrlg_pkg::CHAN_W-1:0]       sat_level;
    logic [rrlg_pkg::CHAN_W-1:0]       value_level;

    pixel_word_t colors_due[$];
    int unsigned mismatch_count;
    int unsigned stall_cycles;
    bit          no_idle;

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // roughly 15 idle cycles in a hundred unless a no-idle stretch is running
    function automatic bit idle_roll();
        return !no_idle && ($urandom_range(99) < 15);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // six-sector HSV to RGB, all integer, truncating like the block does
    function automatic pixel_word_t hsv_pixel(input int unsigned hue, input int unsigned led);
        longint unsigned h6;
        longint unsigned sector;
        longint unsigned frac;
        longint unsigned den;
        longint unsigned s;
        longint unsigned v;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        pixel_word_t     w;
        h6     = longint'(hue) * 6;
        sector = h6 / HUE_TURN;
        frac   = h6 % HUE_TURN;
        den    = 255 * HUE_TURN;
        s      = sat_level;
        v      = value_level;
        p      = (v * (255 - s)) / 255;
        q      = (v * (den - s * frac)) / den;
        t      = (v * (den - s * (HUE_TURN - frac))) / den;
        case (sector)
            0:       begin r = v; g = t; b = p; end
            1:       begin r = q; g = v; b = p; end
            2:       begin r = p; g = v; b = t; end
            3:       begin r = p; g = q; b = v; end
            4:       begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
        endcase
        w.led_index = led[rrlg_pkg::LED_W-1:0];
        w.red       = r[rrlg_pkg::CHAN_W-1:0];
        w.green     = g[rrlg_pkg::CHAN_W-1:0];
        w.blue      = b[rrlg_pkg::CHAN_W-1:0];
        w.last_led  = (led == rrlg_pkg::LEDS - 1);
        return w;
    endfunction

    // true modulo: a negative step still lands in 0..HUE_TURN-1
    function automatic int unsigned wrap_turn(input int h);
        int r;
        r = h % HUE_TURN;
        if (r < 0)
            r += HUE_TURN;
        return r;
    endfunction

    // one accepted tick of 1: advance the ring, queue a pixel word per LED
    // LED offset is truncated to whole hue units
    task automatic predict_frame();
        ring_hue = wrap_turn(int'(ring_hue) + int'(hue_step));
        for (int led = 0; led < rrlg_pkg::LEDS; led++)
            colors_due.push_back(hsv_pixel(
                wrap_turn(int'(ring_hue) + (led * HUE_SPAN) / rrlg_pkg::LEDS), led));
    endtask

    // one frame word; valid stays high afterward so back-to-back words need no gap
    task automatic send_frame(input logic tick);
        bit done;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if (idle_roll())
                frame_if.valid <= 1'b0;
            else
            begin
                frame_if.valid      <= 1'b1;
                frame_if.frame_tick <= tick;
                do
                    @(posedge clk);
                while (!frame_if.ready);
                if (tick)
                    predict_frame();
                done = 1'b1;
            end
        end
    endtask

    // sender stops and waits for every pending pixel word, then a few spare cycles
    task automatic wait_colors_drained();
        @(negedge clk);
        frame_if.valid <= 1'b0;
        while (colors_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write while idle; the predictor takes it at the same time
    task automatic write_reg(input logic [rrlg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rrlg_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
        case (idx)
            rrlg_pkg::REG_ROT_STEP: hue_step    = data;
            rrlg_pkg::REG_SAT:      sat_level   = data[rrlg_pkg::CHAN_W-1:0];
            rrlg_pkg::REG_BRIGHT:   value_level = data[rrlg_pkg::CHAN_W-1:0];
            default: ;
        endcase
    endtask

    // random fill above the 8-bit field so the dropped upper bits toggle too
    function automatic logic [rrlg_pkg::CFG_DATA_W-1:0] chan_data(
        input logic [rrlg_pkg::CHAN_W-1:0] level);
        logic [rrlg_pkg::CFG_DATA_W-1:0] d;
        d = rrlg_pkg::CFG_DATA_W'($urandom);
        d[rrlg_pkg::CHAN_W-1:0] = level;
        return d;
    endfunction

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    // registers at reset: step 16, full saturation and brightness; tick 0 does nothing
    task automatic test_reset_defaults();
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    // zero saturation gives grey at the brightness level, then full black
    task automatic test_grey_levels();
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_SAT, chan_data(8'd0));
        write_reg(rrlg_pkg::REG_BRIGHT, chan_data(8'd200));
        send_frame(1'b1);
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_BRIGHT, chan_data(8'd0));
        send_frame(1'b1);
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_BRIGHT, chan_data(8'd255));
        send_frame(1'b1);
    endtask

    // low saturation plus full saturation with zero brightness
    task automatic test_color_extremes();
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_SAT, chan_data(8'd1));
        send_frame(1'b1);
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_SAT, chan_data(8'd255));
        write_reg(rrlg_pkg::REG_BRIGHT, chan_data(8'd0));
        send_frame(1'b1);
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_BRIGHT, chan_data(8'd255));
    endtask

    // field extremes of the step, negative steps and a zero step
    task automatic test_step_extremes();
        logic [rrlg_pkg::CFG_DATA_W-1:0] steps[6];
        steps = '{13'h0FFF, 13'h1000, 13'h0000, 13'h1FFF, 13'd2880, -13'sd2880};
        foreach (steps[k])
        begin
            wait_colors_drained();
            write_reg(rrlg_pkg::REG_ROT_STEP, steps[k]);
            send_frame(1'b1);
            send_frame(1'b1);
        end
    endtask

    // a write to the unmapped index must leave every register as it was
    task automatic test_unmapped_index();
        wait_colors_drained();
        write_reg(rrlg_pkg::REG_ROT_STEP, 13'd37);
        write_reg(REG_UNMAPPED, '1);
        write_reg(REG_UNMAPPED, 13'h0000);
        send_frame(1'b1);
    endtask

    // ---------------------------------------------------------------
    // random frames in phases, registers rewritten between phases
    // ---------------------------------------------------------------

    task automatic randomize_color_regs();
        logic [rrlg_pkg::CFG_DATA_W-1:0] step;
        logic [rrlg_pkg::CHAN_W-1:0]     level;
        case ($urandom_range(7))
            0:       step = 13'h1000;
            1:       step = 13'h0FFF;
            2:       step = 13'h0000;
            default: step = rrlg_pkg::CFG_DATA_W'($urandom);
        endcase
        write_reg(rrlg_pkg::REG_ROT_STEP, step);
        case ($urandom_range(6))
            0:       level = 8'd0;
            1:       level = 8'd255;
            default: level = rrlg_pkg::CHAN_W'($urandom);
        endcase
        write_reg(rrlg_pkg::REG_SAT, chan_data(level));
        case ($urandom_range(6))
            0:       level = 8'd0;
            1:       level = 8'd255;
            default: level = rrlg_pkg::CHAN_W'($urandom);
        endcase
        write_reg(rrlg_pkg::REG_BRIGHT, chan_data(level));
        if ($urandom_range(4) == 0)
            write_reg(REG_UNMAPPED, rrlg_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned phase;
        int unsigned burst;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_FRAMES)
        begin
            wait_colors_drained();
            randomize_color_regs();
            // one phase runs both sides flat out
            no_idle = (phase == 3);
            burst   = $urandom_range(12, 40);
            for (int k = 0; k < burst; k++)
            begin
                // mid-phase hold-off: sender waits for every pending word
                if (phase == 5 && k == burst / 2)
                    wait_colors_drained();
                send_frame($urandom_range(99) < 85);
                sent++;
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // pixel side: random back-pressure driven at the falling edge
    // ---------------------------------------------------------------
    initial
    begin
        pixel_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pixel_if.ready <= !idle_roll();
        end
    end

    // compare each accepted pixel word with the oldest pending one
    always @(posedge clk)
    begin : check_pixels
        pixel_word_t want;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            if (colors_due.size() == 0)
                report_mismatch("unexpected pixel word, led_index", pixel_if.led_index, -1);
            else
            begin
                want = colors_due.pop_front();
                if (pixel_if.led_index !== want.led_index)
                    report_mismatch("led_index", pixel_if.led_index, want.led_index);
                if (pixel_if.red !== want.red)
                    report_mismatch("red", pixel_if.red, want.red);
                if (pixel_if.green !== want.green)
                    report_mismatch("green", pixel_if.green, want.green);
                if (pixel_if.blue !== want.blue)
                    report_mismatch("blue", pixel_if.blue, want.blue);
                if (pixel_if.last_led !== want.last_led)
                    report_mismatch("last_led", pixel_if.last_led, want.last_led);
            end
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (frame_if.valid && frame_if.ready) || (pixel_if.valid && pixel_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_rotating_rainbow_led_generator: FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = rrlg_pkg::REG_ROT_STEP;
        wr_data             = '0;
        frame_if.valid      = 1'b0;
        frame_if.frame_tick = 1'b0;
        mismatch_count      = 0;
        stall_cycles        = 0;
        no_idle             = 1'b0;
        // predictor mirrors the reset values
        ring_hue            = 0;
        hue_step            = rrlg_pkg::RST_ROT_STEP;
        sat_level           = rrlg_pkg::RST_SAT;
        value_level         = rrlg_pkg::RST_BRIGHT;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_grey_levels();
        test_color_extremes();
        test_step_extremes();
        test_unmapped_index();
        test_random_frames();

        // drain, then give stray words time to show up
        wait_colors_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && colors_due.size() == 0)
            $display("tb_rotating_rainbow_led_generator: PASS");
        else
            $display("tb_rotating_rainbow_led_generator: FAIL");
        $finish;
    end

endmodule
